>>> rtl/kmp_pkg.sv
// shared codes, defaults and control structs of the kmp stream matcher
package kmp_pkg;

  // default pattern capacity in bytes
  localparam int PATTERN_MAX_DEF = 64;

  // input opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_NO_MATCH = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // command broadcast to every cell for one accepted request
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       text;
    logic [7:0] data_byte;
  } kmp_cmd_t;

  // summary of the cell row seen by the top level
  typedef struct packed {
    logic full_match;
    logic empty;
    logic full;
  } kmp_row_stat_t;

endpackage

>>> rtl/kmp_if.sv
// valid/ready channel interfaces for requests and results
interface kmp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface kmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] match_start;

  modport source (output valid, output status, output match_start, input ready);
  modport sink   (input valid, input status, input match_start, output ready);
endinterface

>>> rtl/kmp_cell.sv
// one pattern position: stored byte, fill flag and matched-prefix flag
module kmp_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  kmp_pkg::kmp_cmd_t cmd,
  input  logic              prev_filled,
  input  logic              prev_act,
  input  logic              next_filled,
  output logic              filled,
  output logic              act,
  output logic              hit_last
);

  logic [7:0] pat_r;
  logic       filled_r;
  logic       act_r;
  logic       hit;
  logic       last;

  // prefix through this position extends with the incoming byte
  assign hit      = prev_act & filled_r & (pat_r == cmd.data_byte);
  assign last     = filled_r & ~next_filled;
  assign hit_last = hit & last;
  assign filled   = filled_r;
  assign act      = act_r;

  // fill and match flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      act_r    <= 1'b0;
    end else if (cmd.clear) begin
      filled_r <= 1'b0;
      act_r    <= 1'b0;
    end else if (cmd.append) begin
      filled_r <= filled_r | prev_filled;
    end else if (cmd.text) begin
      // a full match is dropped so the walk falls back to the longest border
      act_r <= hit & ~last;
    end
  end

  // the first empty cell takes the appended byte
  always_ff @(posedge clk) begin
    if (cmd.append && prev_filled && !filled_r) begin
      pat_r <= cmd.data_byte;
    end
  end

endmodule

>>> rtl/kmp_cell_row.sv
// row of pattern cells with neighbor chaining and full-match reduction
module kmp_cell_row #(
  parameter int PATTERN_MAX = kmp_pkg::PATTERN_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmp_pkg::kmp_cmd_t      cmd,
  output kmp_pkg::kmp_row_stat_t stat
);

  logic [PATTERN_MAX-1:0] filled;
  logic [PATTERN_MAX-1:0] act;
  logic [PATTERN_MAX-1:0] hit_last;
  logic [PATTERN_MAX:0]   filled_chain;
  logic [PATTERN_MAX:0]   act_chain;
  logic [PATTERN_MAX:0]   next_chain;

  // chain ends: empty prefix always matches, nothing beyond the last cell
  assign filled_chain = {filled, 1'b1};
  assign act_chain    = {act, 1'b1};
  assign next_chain   = {1'b0, filled};

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    kmp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .prev_filled (filled_chain[i]),
      .prev_act    (act_chain[i]),
      .next_filled (next_chain[i+1]),
      .filled      (filled[i]),
      .act         (act[i]),
      .hit_last    (hit_last[i])
    );
  end

  // row summary
  assign stat.full_match = |hit_last;
  assign stat.empty      = ~filled[0];
  assign stat.full       = filled[PATTERN_MAX-1];

endmodule

>>> rtl/kmp_stream_matcher.sv
// top level of the kmp stream matcher: request handling, position count, result register
// Streaming Knuth-Morris-Pratt matcher. Requests append pattern bytes, clear the pattern
// or stream text bytes; every request gives exactly one result. The pattern lives in a row
// of PATTERN_MAX cells, each holding one byte and a flag for "the prefix through here
// matches the recent text"; a text byte updates all flags at once, so the failure chain
// is never walked. A request is taken whenever the result register is empty or being
// drained, and its result is registered for the next cycle; while results are drained,
// the block sustains one request per cycle, a figure set by the single result register.
// Overlapping matches are reported, match_start wraps modulo 2^32 with the text position.
module kmp_stream_matcher #(
  parameter int PATTERN_MAX = kmp_pkg::PATTERN_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  kmp_in_if.sink          in_chan,
  kmp_out_if.source       out_chan
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic                   in_acc;
  kmp_pkg::kmp_cmd_t      cmd;
  kmp_pkg::kmp_row_stat_t stat;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [31:0]      pos_r;
  logic [31:0]      pos_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [1:0]       status_nxt;
  logic [31:0]      start_r;
  logic [31:0]      start_nxt;

  // handshake
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign in_chan.ready = ~out_valid_r | out_chan.ready;

  // command to the cell row
  assign cmd.clear     = in_acc & (in_chan.opcode == kmp_pkg::OP_CLEAR);
  assign cmd.append    = in_acc & (in_chan.opcode == kmp_pkg::OP_APPEND);
  assign cmd.text      = in_acc & (in_chan.opcode == kmp_pkg::OP_TEXT);
  assign cmd.data_byte = in_chan.data_byte;

  kmp_cell_row #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // result and next length and position
  always_comb begin
    status_nxt = kmp_pkg::ST_NO_MATCH;
    start_nxt  = 32'd0;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    unique case (in_chan.opcode)
      kmp_pkg::OP_CLEAR: begin
        len_nxt = '0;
        pos_nxt = 32'd0;
      end
      kmp_pkg::OP_APPEND: begin
        if (stat.full) begin
          status_nxt = kmp_pkg::ST_FULL;
        end else begin
          len_nxt = len_r + LEN_W'(1);
        end
      end
      kmp_pkg::OP_TEXT: begin
        pos_nxt = pos_r + 32'd1;
        if (stat.empty) begin
          status_nxt = kmp_pkg::ST_EMPTY;
        end else if (stat.full_match) begin
          status_nxt = kmp_pkg::ST_MATCH;
          start_nxt  = pos_r - 32'(len_r) + 32'd1;
        end
      end
      default: begin
        status_nxt = kmp_pkg::ST_NO_MATCH;
      end
    endcase
  end

  // length and text position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pos_r <= 32'd0;
    end else if (in_acc) begin
      len_r <= len_nxt;
      pos_r <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.match_start = start_r;

  // length counter agrees with the cell fill flags
  assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == LEN_W'(0)) == stat.empty)
    else $error("length counter and empty flag disagree");

  assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == LEN_W'(PATTERN_MAX)) == stat.full)
    else $error("length counter and full flag disagree");

  // text on an empty pattern reports empty
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.text && (len_r == LEN_W'(0)) |=> status_r == kmp_pkg::ST_EMPTY)
    else $error("text on empty pattern not reported");

  // match start is zero unless a match is reported
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != kmp_pkg::ST_MATCH) |-> start_r == 32'd0)
    else $error("nonzero match start without a match");

endmodule
